// ===== hdl/psg_pkg.sv =====
// Shared types and constants for the three-tone sound generator.
`timescale 1ns / 1ps
package psg_pkg;
	localparam int DVD_W = 13;
	localparam int DVS_W = 12;
	localparam int QUO_W = 5;
	localparam int DCNT_W = 4;

	localparam logic [1:0] OP_ADDR  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [3:0] REG_TONE_A_L = 4'd0;
	localparam logic [3:0] REG_TONE_A_H = 4'd1;
	localparam logic [3:0] REG_TONE_B_L = 4'd2;
	localparam logic [3:0] REG_TONE_B_H = 4'd3;
	localparam logic [3:0] REG_NOISE = 4'd6;
	localparam logic [3:0] REG_MIXER = 4'd7;
	localparam logic [3:0] REG_VOL_A = 4'd8;
	localparam logic [3:0] REG_VOL_B = 4'd9;
	localparam logic [3:0] REG_VOL_C = 4'd10;
	localparam logic [3:0] REG_ENV_L = 4'd11;
	localparam logic [3:0] REG_ENV_H = 4'd12;
	localparam logic [3:0] REG_SHAPE = 4'd13;
	localparam logic [3:0] REG_PORT_B = 4'd15;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;
endpackage

// ===== hdl/psg_three_tone_noise_envelope.sv =====
// Top level of the three-tone sound generator with noise and envelope.
`timescale 1ns / 1ps
// Use: each input item is a bus access or one tick (opcode, bus_byte) on a
// valid/ready channel; every item gives exactly one result item on the output
// valid/ready channel (read_byte, gated channel levels, envelope flags, noise).
// Address, data write and data read items go from acceptance straight to the
// finish state. A tick walks the three tone dividers in turn through one
// shared restoring divider: a channel whose count stays below its period just
// counts up, while one that wraps goes through a start step, one division
// step per dividend bit and a done step. Noise and envelope advance in
// the cycle the tick is accepted.
// in_ready is high only while the sequencer is idle; one item is in work at a time.
// The result sits in an output register; if the receiver stalls, a finished
// item waits until that register is free, and in_ready stays low meanwhile.
// Reset (arst_n low) clears the register file, deselects the chip, sets the
// noise shift register to one and the envelope to shape zero; no output is valid.
module psg_three_tone_noise_envelope #(
	parameter int ENV_STEP_MULT = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] bus_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_byte,
	output logic [3:0] level_a,
	output logic [3:0] level_b,
	output logic [3:0] level_c,
	output logic       env_mode_a,
	output logic       env_mode_b,
	output logic       env_mode_c,
	output logic       noise_level
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TONE = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  ch_q;
	logic [7:0]  reg_q [16];
	logic [3:0]  sel_q;
	logic        active_q;
	logic [16:0] lfsr_q;
	logic [4:0]  ncnt_q;
	logic        npre_q;
	logic [11:0] tcnt_q [3];
	logic [4:0]  tduty_q [3];
	logic        tout_q [3];
	logic [16:0] ecnt_q;
	logic [4:0]  estep_q;
	logic        eatt_q;
	logic        ehold_q;
	logic        ealt_q;
	logic        eholding_q;
	logic [7:0]  rd_q;

	logic        out_valid_q;
	logic [7:0]  read_byte_q;
	logic [3:0]  level_q [3];
	logic        envm_q [3];
	logic        noise_q;

	psg_pkg::div_req_t div_req;
	psg_pkg::div_rsp_t div_rsp;

	logic        accept;
	logic        fin_go;
	logic [11:0] raw_per;
	logic [11:0] tper;
	logic [12:0] tc_next;
	logic [5:0]  ncnt_next;
	logic [16:0] ecnt_next;
	logic [17:0] eper;
	logic [4:0]  estep_dec;
	logic [3:0]  evol;
	logic [4:0]  duty_new;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign raw_per  = {reg_q[{1'b0, ch_q, 1'b1}][3:0], reg_q[{1'b0, ch_q, 1'b0}]};
	assign tper     = (raw_per == 12'd0) ? 12'd1 : raw_per;
	assign tc_next  = {1'b0, tcnt_q[ch_q]} + 13'd1;
	assign ncnt_next = {1'b0, ncnt_q} + 6'd1;
	assign ecnt_next = ecnt_q + 17'd1;
	assign eper      = 18'({reg_q[psg_pkg::REG_ENV_H], reg_q[psg_pkg::REG_ENV_L]} *
		ENV_STEP_MULT);
	assign estep_dec = estep_q - 5'd1;
	assign evol      = estep_q[3:0] ^ {4{eatt_q}};
	assign duty_new  = tduty_q[ch_q] - div_rsp.quo;

	always_comb begin
		div_req.start    = (state_q == ST_TONE) && (tc_next >= {1'b0, tper});
		div_req.dividend = tc_next;
		div_req.divisor  = tper;
	end

	psg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ch_q       <= 2'd0;
			for (int i = 0; i < 16; i++)
				reg_q[i] <= 8'h00;
			sel_q      <= 4'd0;
			active_q   <= 1'b0;
			lfsr_q     <= 17'd1;
			ncnt_q     <= 5'd0;
			npre_q     <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				tcnt_q[i]  <= 12'd0;
				tduty_q[i] <= 5'd0;
				tout_q[i]  <= 1'b0;
			end
			ecnt_q     <= 17'd0;
			estep_q    <= 5'd15;
			eatt_q     <= 1'b0;
			ehold_q    <= 1'b1;
			ealt_q     <= 1'b0;
			eholding_q <= 1'b0;
			rd_q       <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q    <= 8'h00;
						state_q <= ST_FIN;
						case (opcode)
							psg_pkg::OP_ADDR: begin
								if (bus_byte[7:4] == 4'd0) begin
									active_q <= 1'b1;
									sel_q    <= bus_byte[3:0];
								end else begin
									active_q <= 1'b0;
								end
							end
							psg_pkg::OP_WRITE: begin
								if (active_q) begin
									reg_q[sel_q] <= bus_byte;
									if (sel_q == psg_pkg::REG_SHAPE) begin
										eatt_q <= bus_byte[2];
										if (!bus_byte[3]) begin
											ehold_q <= 1'b1;
											ealt_q  <= bus_byte[2];
										end else begin
											ehold_q <= bus_byte[0];
											ealt_q  <= bus_byte[1];
										end
										estep_q    <= 5'd15;
										eholding_q <= 1'b0;
									end
								end
							end
							psg_pkg::OP_READ: begin
								rd_q <= active_q ? reg_q[sel_q] : 8'hff;
							end
							psg_pkg::OP_TICK: begin
								// tick: noise and envelope now, tones in the sequencer
								state_q <= ST_TONE;
								ch_q    <= 2'd0;
								if (ncnt_next >= {1'b0, reg_q[psg_pkg::REG_NOISE][4:0]}) begin
									ncnt_q <= 5'd0;
									npre_q <= !npre_q;
									if (npre_q)
										lfsr_q <= {lfsr_q[0] ^ lfsr_q[3], lfsr_q[16:1]};
								end else begin
									ncnt_q <= ncnt_next[4:0];
								end
								if (!eholding_q) begin
									if ({1'b0, ecnt_next} >= eper) begin
										ecnt_q <= 17'd0;
										if (estep_dec[4]) begin
											if (ealt_q)
												eatt_q <= !eatt_q;
											if (ehold_q) begin
												eholding_q <= 1'b1;
												estep_q    <= 5'd0;
											end else begin
												estep_q <= {1'b0, estep_dec[3:0]};
											end
										end else begin
											estep_q <= estep_dec;
										end
									end else begin
										ecnt_q <= ecnt_next;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_TONE: begin
					if (div_req.start) begin
						state_q <= ST_DIV;
					end else begin
						tcnt_q[ch_q] <= tc_next[11:0];
						if (ch_q == 2'd2)
							state_q <= ST_FIN;
						else
							ch_q <= ch_q + 2'd1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						tduty_q[ch_q] <= duty_new;
						tout_q[ch_q]  <= duty_new[0];
						tcnt_q[ch_q]  <= div_rsp.rem;
						if (ch_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_TONE;
						end
					end
				end
				default: begin
					if (fin_go)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result capture as the item leaves the sequencer
	always_ff @(posedge clk) begin
		if (fin_go) begin
			read_byte_q <= rd_q;
			noise_q     <= lfsr_q[0];
			for (int i = 0; i < 3; i++) begin
				envm_q[i]  <= reg_q[psg_pkg::REG_VOL_A + 4'(i)][4];
				level_q[i] <= ((tout_q[i] | reg_q[psg_pkg::REG_MIXER][i]) &
					(lfsr_q[0] | reg_q[psg_pkg::REG_MIXER][3 + i])) ?
					(reg_q[psg_pkg::REG_VOL_A + 4'(i)][4] ? evol :
					reg_q[psg_pkg::REG_VOL_A + 4'(i)][3:0]) : 4'd0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign read_byte   = read_byte_q;
	assign level_a     = level_q[0];
	assign level_b     = level_q[1];
	assign level_c     = level_q[2];
	assign env_mode_a  = envm_q[0];
	assign env_mode_b  = envm_q[1];
	assign env_mode_c  = envm_q[2];
	assign noise_level = noise_q;
endmodule

// ===== hdl/psg_div.sv =====
// Restoring divider, one quotient bit a cycle; keeps the low quotient bits only.
`timescale 1ns / 1ps
module psg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  psg_pkg::div_req_t  req,
	output psg_pkg::div_rsp_t  rsp
);
	localparam logic [psg_pkg::DCNT_W-1:0] LAST = psg_pkg::DCNT_W'(psg_pkg::DVD_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [psg_pkg::DCNT_W-1:0]    cnt_q;
	logic [psg_pkg::DVD_W-1:0]     dvd_q;
	logic [psg_pkg::DVS_W-1:0]     dvs_q;
	logic [psg_pkg::DVS_W-1:0]     rem_q;
	logic [psg_pkg::QUO_W-1:0]     quo_q;
	logic [psg_pkg::DVS_W:0]       shifted;
	logic [psg_pkg::DVS_W:0]       diff;
	logic                          ge;

	assign shifted = {rem_q, dvd_q[psg_pkg::DVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[psg_pkg::DVD_W-2:0], 1'b0};
			// remainder stays below the divisor, so it fits the divisor width
			rem_q <= ge ? diff[psg_pkg::DVS_W-1:0] : shifted[psg_pkg::DVS_W-1:0];
			quo_q <= {quo_q[psg_pkg::QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;
endmodule
